// File: src/segi_pkg.sv
`default_nettype none
package segi_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * CoordW + 1;
  localparam int DenW   = 2 * CoordW + 3;
  localparam int NumW   = 3 * CoordW + 3;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CoordW-1:0] a0_x;
    logic signed [CoordW-1:0] a0_y;
    logic signed [CoordW-1:0] a1_x;
    logic signed [CoordW-1:0] a1_y;
    logic signed [CoordW-1:0] b0_x;
    logic signed [CoordW-1:0] b0_y;
    logic signed [CoordW-1:0] b1_x;
    logic signed [CoordW-1:0] b1_y;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [CoordW-1:0] cross_x;
    logic signed [CoordW-1:0] cross_y;
  } out_item_t;

  typedef struct packed {
    logic            valid;
    status_t         status;
    logic            neg_x;
    logic            neg_y;
    logic [NumW-1:0] mag_x;
    logic [NumW-1:0] mag_y;
    logic [DenW-1:0] den;
  } div_job_t;

endpackage
`default_nettype wire

// File: src/segi_geom.sv
`default_nettype none
module segi_geom (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire segi_pkg::in_item_t   in_item,
  output segi_pkg::div_job_t        job
);

  localparam int W  = segi_pkg::CoordW;
  localparam int DW = segi_pkg::DiffW;
  localparam int PW = segi_pkg::ProdW;
  localparam int EW = segi_pkg::DenW;
  localparam int NW = segi_pkg::NumW;

  typedef logic signed [W-1:0]  crd_t;
  typedef logic signed [DW-1:0] dif_t;
  typedef logic signed [PW-1:0] prd_t;
  typedef logic signed [EW-1:0] den_t;
  typedef logic signed [NW-1:0] num_t;

  // Stage 1: differences and the overlap of the two bounding boxes.
  crd_t lox, hix, loy, hiy;
  logic v1_r;
  segi_pkg::in_item_t c1_r;
  dif_t dx12_1_r, dy12_1_r, dx34_1_r, dy34_1_r;
  crd_t lox1_r, hix1_r, loy1_r, hiy1_r;

  function automatic crd_t fmin(input crd_t a, input crd_t b);
    fmin = (a < b) ? a : b;
  endfunction

  function automatic crd_t fmax(input crd_t a, input crd_t b);
    fmax = (a > b) ? a : b;
  endfunction

  always_comb begin
    lox = fmax(fmin(in_item.a0_x, in_item.a1_x), fmin(in_item.b0_x, in_item.b1_x));
    hix = fmin(fmax(in_item.a0_x, in_item.a1_x), fmax(in_item.b0_x, in_item.b1_x));
    loy = fmax(fmin(in_item.a0_y, in_item.a1_y), fmin(in_item.b0_y, in_item.b1_y));
    hiy = fmin(fmax(in_item.a0_y, in_item.a1_y), fmax(in_item.b0_y, in_item.b1_y));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r     <= in_item;
      dx12_1_r <= DW'(in_item.a0_x) - DW'(in_item.a1_x);
      dy12_1_r <= DW'(in_item.a0_y) - DW'(in_item.a1_y);
      dx34_1_r <= DW'(in_item.b0_x) - DW'(in_item.b1_x);
      dy34_1_r <= DW'(in_item.b0_y) - DW'(in_item.b1_y);
      lox1_r   <= lox;
      hix1_r   <= hix;
      loy1_r   <= loy;
      hiy1_r   <= hiy;
    end
  end

  // Stage 2: determinant and the two cross terms.
  logic signed [2*DW-1:0] pd1, pd2;
  logic signed [2*W-1:0]  pa1, pa2, pb1, pb2;
  logic v2_r;
  den_t d2_r;
  prd_t pre2_r, post2_r;
  dif_t dx12_2_r, dy12_2_r, dx34_2_r, dy34_2_r;
  crd_t lox2_r, hix2_r, loy2_r, hiy2_r;

  always_comb begin
    pd1 = dx12_1_r * dy34_1_r;
    pd2 = dy12_1_r * dx34_1_r;
    pa1 = c1_r.a0_x * c1_r.a1_y;
    pa2 = c1_r.a0_y * c1_r.a1_x;
    pb1 = c1_r.b0_x * c1_r.b1_y;
    pb2 = c1_r.b0_y * c1_r.b1_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r     <= EW'(pd1) - EW'(pd2);
      pre2_r   <= PW'(pa1) - PW'(pa2);
      post2_r  <= PW'(pb1) - PW'(pb2);
      dx12_2_r <= dx12_1_r;
      dy12_2_r <= dy12_1_r;
      dx34_2_r <= dx34_1_r;
      dy34_2_r <= dy34_1_r;
      lox2_r   <= lox1_r;
      hix2_r   <= hix1_r;
      loy2_r   <= loy1_r;
      hiy2_r   <= hiy1_r;
    end
  end

  // Stage 3: numerators and the magnitude of the determinant.
  logic signed [PW+DW-1:0] mx1, mx2, my1, my2;
  logic v3_r, dneg3_r, dzero3_r;
  num_t nx3_r, ny3_r;
  den_t dabs3_r;
  crd_t lox3_r, hix3_r, loy3_r, hiy3_r;

  always_comb begin
    mx1 = pre2_r * dx34_2_r;
    mx2 = dx12_2_r * post2_r;
    my1 = pre2_r * dy34_2_r;
    my2 = dy12_2_r * post2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx3_r    <= NW'(mx1) - NW'(mx2);
      ny3_r    <= NW'(my1) - NW'(my2);
      dneg3_r  <= d2_r[EW-1];
      dzero3_r <= (d2_r == '0);
      dabs3_r  <= d2_r[EW-1] ? -d2_r : d2_r;
      lox3_r   <= lox2_r;
      hix3_r   <= hix2_r;
      loy3_r   <= loy2_r;
      hiy3_r   <= hiy2_r;
    end
  end

  // Stage 4: numerators brought to a positive denominator, box limits scaled.
  logic signed [W+EW-1:0] blx, bhx, bly, bhy;
  logic v4_r, dzero4_r;
  num_t nx4_r, ny4_r, lx4_r, hx4_r, ly4_r, hy4_r;
  den_t dabs4_r;

  always_comb begin
    blx = lox3_r * dabs3_r;
    bhx = hix3_r * dabs3_r;
    bly = loy3_r * dabs3_r;
    bhy = hiy3_r * dabs3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx4_r    <= dneg3_r ? -nx3_r : nx3_r;
      ny4_r    <= dneg3_r ? -ny3_r : ny3_r;
      lx4_r    <= NW'(blx);
      hx4_r    <= NW'(bhx);
      ly4_r    <= NW'(bly);
      hy4_r    <= NW'(bhy);
      dabs4_r  <= dabs3_r;
      dzero4_r <= dzero3_r;
    end
  end

  // Stage 5: classification and sign-magnitude form for the divider.
  logic outside;
  segi_pkg::status_t st;
  segi_pkg::div_job_t job_r;

  always_comb begin
    outside = (nx4_r < lx4_r) || (hx4_r < nx4_r) || (ny4_r < ly4_r) || (hy4_r < ny4_r);
    if (dzero4_r) begin
      st = segi_pkg::ST_PARALLEL;
    end else if (outside) begin
      st = segi_pkg::ST_OUTSIDE;
    end else begin
      st = segi_pkg::ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r.valid <= 1'b0;
    end else if (en) begin
      job_r.valid <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job_r.status <= st;
      job_r.neg_x  <= nx4_r[NW-1];
      job_r.neg_y  <= ny4_r[NW-1];
      job_r.mag_x  <= nx4_r[NW-1] ? NW'(-nx4_r) : NW'(nx4_r);
      job_r.mag_y  <= ny4_r[NW-1] ? NW'(-ny4_r) : NW'(ny4_r);
      job_r.den    <= EW'(dabs4_r);
    end
  end

  assign job = job_r;

endmodule
`default_nettype wire

// File: src/segi_div.sv
`default_nettype none
module segi_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire segi_pkg::div_job_t            job_i,
  output segi_pkg::div_job_t                 job_o,
  output logic [segi_pkg::CoordW-1:0]        qx_o,
  output logic [segi_pkg::CoordW-1:0]        qy_o
);

  localparam int W  = segi_pkg::CoordW;
  localparam int NW = segi_pkg::NumW;

  segi_pkg::div_job_t job_r [W];
  logic [NW-1:0] rx_r [W];
  logic [NW-1:0] ry_r [W];
  logic [W-1:0]  qx_r [W];
  logic [W-1:0]  qy_r [W];

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int Sh = W - 1 - k;
    segi_pkg::div_job_t j_in;
    logic [NW-1:0] rx_in, ry_in, rx_nxt, ry_nxt;
    logic [W-1:0]  qx_in, qy_in;
    logic [NW:0]   dsh;
    logic          gx, gy;

    if (k == 0) begin : g_first
      assign j_in  = job_i;
      assign rx_in = job_i.mag_x;
      assign ry_in = job_i.mag_y;
      assign qx_in = '0;
      assign qy_in = '0;
    end else begin : g_next
      assign j_in  = job_r[k-1];
      assign rx_in = rx_r[k-1];
      assign ry_in = ry_r[k-1];
      assign qx_in = qx_r[k-1];
      assign qy_in = qy_r[k-1];
    end

    always_comb begin
      dsh    = (NW + 1)'(j_in.den) << Sh;
      gx     = {1'b0, rx_in} >= dsh;
      gy     = {1'b0, ry_in} >= dsh;
      rx_nxt = gx ? NW'({1'b0, rx_in} - dsh) : rx_in;
      ry_nxt = gy ? NW'({1'b0, ry_in} - dsh) : ry_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        job_r[k].valid <= 1'b0;
      end else if (en) begin
        job_r[k].valid <= j_in.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        job_r[k].status <= j_in.status;
        job_r[k].neg_x  <= j_in.neg_x;
        job_r[k].neg_y  <= j_in.neg_y;
        job_r[k].mag_x  <= j_in.mag_x;
        job_r[k].mag_y  <= j_in.mag_y;
        job_r[k].den    <= j_in.den;
        rx_r[k]         <= rx_nxt;
        ry_r[k]         <= ry_nxt;
        qx_r[k]         <= qx_in | (W'(gx) << Sh);
        qy_r[k]         <= qy_in | (W'(gy) << Sh);
      end
    end
  end

  assign job_o = job_r[W-1];
  assign qx_o  = qx_r[W-1];
  assign qy_o  = qy_r[W-1];

endmodule
`default_nettype wire

// File: src/segment_intersection.sv
`default_nettype none
// Intersects two 2D segments given as signed Q12.4 endpoints and returns a status
// (hit, parallel, outside) with the crossing point truncated toward zero, or (0,0)
// when there is no hit. One item enters per cycle and passes through five stages of
// multiply and compare work, sixteen stages of the restoring divider that yields one
// quotient bit per stage, and the output register. A stall on the result channel
// while a result is valid holds the whole pipeline.
module segment_intersection (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire segi_pkg::in_item_t    in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output segi_pkg::out_item_t        out_item
);

  localparam int W = segi_pkg::CoordW;

  logic en;
  segi_pkg::div_job_t geo_job, div_job;
  logic [W-1:0] qx, qy;
  logic out_valid_r;
  segi_pkg::out_item_t out_item_r, out_item_nxt;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  segi_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_valid),
    .in_item (in_item),
    .job     (geo_job)
  );

  segi_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .job_i(geo_job),
    .job_o(div_job),
    .qx_o (qx),
    .qy_o (qy)
  );

  always_comb begin
    out_item_nxt.status  = div_job.status;
    out_item_nxt.cross_x = '0;
    out_item_nxt.cross_y = '0;
    if (div_job.status == segi_pkg::ST_HIT) begin
      out_item_nxt.cross_x = div_job.neg_x ? -qx : qx;
      out_item_nxt.cross_y = div_job.neg_y ? -qy : qy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_job.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != segi_pkg::ST_HIT |->
      out_item.cross_x == '0 && out_item.cross_y == '0)
    else $error("miss reported with a nonzero point");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output stall");

  a_hold_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(out_item.status) && out_valid)
    else $error("pipeline moved while held");
`endif

endmodule
`default_nettype wire
